[hw/rtl/hsp_pkg.sv]
// Shared types, codes and controller/datapath interface of the scope profiler.
package hsp_pkg;

    localparam int IDX_W = 12;
    localparam int TS_W  = 64;

    // request codes
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] anchor_index;
        logic [TS_W-1:0]  timestamp;
    } t_in_word;

    typedef struct packed {
        logic [1:0]      status;
        logic [TS_W-1:0] exclusive_time;
        logic [TS_W-1:0] inclusive_time;
        logic [TS_W-1:0] hit_total;
    } t_out_word;

    // counter table port operation
    typedef enum logic [2:0] {
        TBL_NONE,
        TBL_RD_SLOT,
        TBL_RD_PARENT,
        TBL_RD_ANCHOR,
        TBL_WR_CLEAR,
        TBL_WR_PARENT,
        TBL_WR_ANCHOR
    } t_tbl_op;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       calc_slot;
        t_tbl_op    tbl_op;
        logic       push;
        logic       pop_rd;
        logic       pop_take;
        logic       set_res;
        logic       res_counters;
        logic [1:0] res_status;
        logic       load_out;
        logic       clr_step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       stack_full;
        logic       stack_empty;
        logic       clr_last;
    } t_dp_stat;

endpackage

[hw/rtl/hierarchical_scope_profiler.sv]
// Top level of the hierarchical scope profiler: controller plus datapath.
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_stall    i_in_word  (t_in_word)
//  out      from block o_out_valid / i_out_stall  o_out_word (t_out_word)
//
// A dropped word or one of unused type goes straight to hand-over; begin and read
// each take one table read; end takes the longest path, since the single-port counter
// table with its registered read forces a parent then anchor read-modify-write.
// After reset a clearing pass zeroes every table entry; no word is accepted
// meanwhile. One result word may wait in the output register while the next
// word is accepted; an output stall holds the block only at hand-over.
module hierarchical_scope_profiler import hsp_pkg::*; #(
    parameter int ANCHOR_COUNT = 4096,
    parameter int STACK_DEPTH  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    hsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    hsp_datapath #(
        .ANCHOR_COUNT (ANCHOR_COUNT),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (i_in_word),
        .o_stat     (w_stat),
        .o_out_word (o_out_word)
    );

endmodule

[hw/rtl/hsp_datapath.sv]
// Datapath of the scope profiler: counter table, scope stack, slot reduction, result registers.
module hsp_datapath import hsp_pkg::*; #(
    parameter int ANCHOR_COUNT = 4096,
    parameter int STACK_DEPTH  = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_word  i_in_word,
    output t_dp_stat  o_stat,
    output t_out_word o_out_word
);

    localparam int AW    = $clog2(ANCHOR_COUNT);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int SIW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef struct packed {
        logic [TS_W-1:0] excl;
        logic [TS_W-1:0] incl;
        logic [TS_W-1:0] hits;
    } t_counters;

    typedef struct packed {
        logic [AW-1:0]   anchor;
        logic [AW-1:0]   parent;
        logic [TS_W-1:0] start;
        logic [TS_W-1:0] saved;
    } t_stk_entry;

    // captured request word
    logic [1:0]       r_kind;
    logic [IDX_W-1:0] r_raw;
    logic [TS_W-1:0]  r_ts;
    logic [AW-1:0]    r_slot;
    logic [AW-1:0]    w_slot;

    // control state
    logic [AW-1:0]    r_parent;
    logic [SPW-1:0]   r_sp;
    logic [AW-1:0]    r_clr;

    // working registers
    logic [TS_W-1:0]  r_elapsed;
    t_counters        r_tbl_q;
    t_stk_entry       r_stk_q;
    t_out_word        r_res;
    t_out_word        r_out;

    // memories
    t_counters        tbl_mem [ANCHOR_COUNT];
    t_stk_entry       stk_mem [STACK_DEPTH];

    logic [AW-1:0]    w_addr;
    logic             w_we;
    logic             w_re;
    t_counters        w_wdata;
    logic [SPW-1:0]   w_sp_dec;

    // capture the request word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in_word.req_type;
            r_raw  <= i_in_word.anchor_index;
            r_ts   <= i_in_word.timestamp;
        end
        if (i_cmd.calc_slot) begin
            r_slot <= w_slot;
        end
    end

    // anchor index modulo table size
    generate
        if (ANCHOR_COUNT >= (1 << IDX_W)) begin : g_wide
            assign w_slot = AW'(r_raw);
        end else begin : g_mod
            // reciprocal multiply; exact for every 12-bit index
            localparam int SHIFT = IDX_W + AW;
            localparam int RECIP = ((1 << SHIFT) + ANCHOR_COUNT - 1) / ANCHOR_COUNT;
            logic [IDX_W+SHIFT-1:0] w_prod;
            logic [IDX_W-1:0]       r_quot;
            logic [IDX_W-1:0]       w_rem;

            assign w_prod = (IDX_W + SHIFT)'(i_in_word.anchor_index)
                          * (IDX_W + SHIFT)'(RECIP);

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_quot <= w_prod[SHIFT +: IDX_W];
                end
            end

            assign w_rem  = r_raw - IDX_W'(r_quot * ANCHOR_COUNT);
            // correction step
            assign w_slot = (w_rem >= IDX_W'(ANCHOR_COUNT))
                          ? AW'(w_rem - IDX_W'(ANCHOR_COUNT)) : AW'(w_rem);
        end
    endgenerate

    // stack pointer, current parent, clear sweep address
    assign w_sp_dec = r_sp - SPW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_parent <= '0;
            r_clr    <= '0;
        end else begin
            if (i_cmd.push) begin
                r_sp     <= r_sp + SPW'(1);
                r_parent <= r_slot;
            end else if (i_cmd.pop_rd) begin
                r_sp     <= w_sp_dec;
            end
            if (i_cmd.pop_take) begin
                r_parent <= r_stk_q.parent;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    // scope stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            stk_mem[r_sp[SIW-1:0]] <= '{anchor: r_slot, parent: r_parent,
                                        start: r_ts, saved: r_tbl_q.incl};
        end
        if (i_cmd.pop_rd) begin
            r_stk_q <= stk_mem[w_sp_dec[SIW-1:0]];
        end
        if (i_cmd.pop_take) begin
            r_elapsed <= r_ts - r_stk_q.start;
        end
    end

    // counter table port
    always_comb begin
        w_addr  = r_slot;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wdata = r_tbl_q;
        case (i_cmd.tbl_op)
            TBL_RD_SLOT: begin
                w_re = 1'b1;
            end
            TBL_RD_PARENT: begin
                w_addr = r_stk_q.parent;
                w_re   = 1'b1;
            end
            TBL_RD_ANCHOR: begin
                w_addr = r_stk_q.anchor;
                w_re   = 1'b1;
            end
            TBL_WR_CLEAR: begin
                w_addr  = r_clr;
                w_we    = 1'b1;
                w_wdata = '0;
            end
            TBL_WR_PARENT: begin
                w_addr       = r_stk_q.parent;
                w_we         = 1'b1;
                w_wdata.excl = r_tbl_q.excl - r_elapsed;
            end
            TBL_WR_ANCHOR: begin
                w_addr       = r_stk_q.anchor;
                w_we         = 1'b1;
                w_wdata.excl = r_tbl_q.excl + r_elapsed;
                w_wdata.incl = r_stk_q.saved + r_elapsed;
                w_wdata.hits = r_tbl_q.hits + TS_W'(1);
            end
            default: begin
                w_addr = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            tbl_mem[w_addr] <= w_wdata;
        end
        if (w_re) begin
            r_tbl_q <= tbl_mem[w_addr];
        end
    end

    // result staging and output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res.status         <= i_cmd.res_status;
            r_res.exclusive_time <= i_cmd.res_counters ? r_tbl_q.excl : '0;
            r_res.inclusive_time <= i_cmd.res_counters ? r_tbl_q.incl : '0;
            r_res.hit_total      <= i_cmd.res_counters ? r_tbl_q.hits : '0;
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_word         = r_out;
    assign o_stat.req_type    = r_kind;
    assign o_stat.stack_full  = (r_sp == SPW'(STACK_DEPTH));
    assign o_stat.stack_empty = (r_sp == '0);
    assign o_stat.clr_last    = (r_clr == AW'(ANCHOR_COUNT - 1));

    // stack bookkeeping checks
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_sp != SPW'(STACK_DEPTH))
        else $error("push into full stack");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_rd |=> r_sp == $past(w_sp_dec))
        else $error("pop did not lower stack pointer");

endmodule

[hw/rtl/hsp_ctrl.sv]
// Controller state machine of the scope profiler.
module hsp_ctrl import hsp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_B_RD,
        S_B_PUSH,
        S_E_POP,
        S_E_TAKE,
        S_E_WRP,
        S_E_RDA,
        S_E_WRA,
        S_R_RD,
        S_R_OUT,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_dp_cmd w_cmd;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.tbl_op   = TBL_WR_CLEAR;
                w_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_SLOT;
                end
            end
            S_SLOT: begin
                w_cmd.calc_slot = 1'b1;
                case (i_stat.req_type)
                    REQ_BEGIN: begin
                        if (i_stat.stack_full) begin
                            w_cmd.set_res    = 1'b1;
                            w_cmd.res_status = ST_FULL;
                            n_state          = S_DONE;
                        end else begin
                            n_state = S_B_RD;
                        end
                    end
                    REQ_END: begin
                        if (i_stat.stack_empty) begin
                            w_cmd.set_res    = 1'b1;
                            w_cmd.res_status = ST_EMPTY;
                            n_state          = S_DONE;
                        end else begin
                            n_state = S_E_POP;
                        end
                    end
                    REQ_READ: begin
                        n_state = S_R_RD;
                    end
                    default: begin
                        // unused request code: empty ok result
                        w_cmd.set_res    = 1'b1;
                        w_cmd.res_status = ST_OK;
                        n_state          = S_DONE;
                    end
                endcase
            end
            S_B_RD: begin
                w_cmd.tbl_op = TBL_RD_SLOT;
                n_state      = S_B_PUSH;
            end
            S_B_PUSH: begin
                w_cmd.push       = 1'b1;
                w_cmd.set_res    = 1'b1;
                w_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            S_E_POP: begin
                w_cmd.pop_rd = 1'b1;
                n_state      = S_E_TAKE;
            end
            S_E_TAKE: begin
                w_cmd.pop_take = 1'b1;
                w_cmd.tbl_op   = TBL_RD_PARENT;
                n_state        = S_E_WRP;
            end
            S_E_WRP: begin
                w_cmd.tbl_op = TBL_WR_PARENT;
                n_state      = S_E_RDA;
            end
            S_E_RDA: begin
                w_cmd.tbl_op = TBL_RD_ANCHOR;
                n_state      = S_E_WRA;
            end
            S_E_WRA: begin
                w_cmd.tbl_op     = TBL_WR_ANCHOR;
                w_cmd.set_res    = 1'b1;
                w_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            S_R_RD: begin
                w_cmd.tbl_op = TBL_RD_SLOT;
                n_state      = S_R_OUT;
            end
            S_R_OUT: begin
                w_cmd.set_res      = 1'b1;
                w_cmd.res_counters = 1'b1;
                w_cmd.res_status   = ST_OK;
                n_state            = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // output hand-over checks
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("output word raised outside hand-over");

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_out_stall) |=> (r_out_valid && r_state == S_IDLE))
        else $error("hand-over did not complete");

endmodule

[sim/hierarchical_scope_profiler_test.sv]
// Self-checking testbench for the hierarchical scope profiler.
`timescale 1ns / 1ps

module hierarchical_scope_profiler_test;
    import hsp_pkg::*;

    localparam int ANCHORS      = 4096;
    localparam int DEPTH        = 64;
    localparam int RANDOM_WORDS = 1200;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam int IDLE_PCT     = 28;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 600;

    // request code the block treats as a no-op
    localparam logic [1:0] REQ_NOP = 2'd3;

    // one open scope as the profiler keeps it
    typedef struct packed {
        logic [IDX_W-1:0] anchor;
        logic [IDX_W-1:0] parent;
        logic [TS_W-1:0]  start;
        logic [TS_W-1:0]  saved_incl;
    } t_open_scope;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    hierarchical_scope_profiler #(
        .ANCHOR_COUNT(ANCHORS),
        .STACK_DEPTH (DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // predicted profiler state
    logic [TS_W-1:0]  excl_tbl [ANCHORS];
    logic [TS_W-1:0]  incl_tbl [ANCHORS];
    logic [TS_W-1:0]  hits_tbl [ANCHORS];
    t_open_scope      open_scopes [DEPTH];
    int unsigned      open_depth;
    logic [IDX_W-1:0] parent_now;

    t_in_word    pending_events [$];
    t_out_word   expected_results [$];
    logic [TS_W-1:0] stamp_now;
    logic        in_took = 1'b0;
    int unsigned words_in = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;
    logic        calm;

    assign calm = (words_in >= CALM_FROM) && (words_in < CALM_TO);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one event word to the predicted state and return the result word
    function automatic t_out_word profile_event(t_in_word w);
        t_out_word        r;
        t_open_scope      e;
        logic [TS_W-1:0]  elapsed;
        logic [IDX_W-1:0] slot;
        r = '0;
        slot = w.anchor_index;
        r.status = ST_OK;
        case (w.req_type)
            REQ_BEGIN: begin
                if (open_depth >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    e.anchor     = slot;
                    e.parent     = parent_now;
                    e.start      = w.timestamp;
                    e.saved_incl = incl_tbl[slot];
                    open_scopes[open_depth] = e;
                    open_depth++;
                    parent_now = slot;
                end
            end
            REQ_END: begin
                if (open_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    open_depth--;
                    e = open_scopes[open_depth];
                    elapsed = w.timestamp - e.start;
                    parent_now = e.parent;
                    excl_tbl[e.parent] = excl_tbl[e.parent] - elapsed;
                    excl_tbl[e.anchor] = excl_tbl[e.anchor] + elapsed;
                    incl_tbl[e.anchor] = e.saved_incl + elapsed;
                    hits_tbl[e.anchor] = hits_tbl[e.anchor] + 1'b1;
                end
            end
            REQ_READ: begin
                r.exclusive_time = excl_tbl[slot];
                r.inclusive_time = incl_tbl[slot];
                r.hit_total      = hits_tbl[slot];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // timestamps mostly creep forward, with rare jumps anywhere in the range
    function automatic logic [TS_W-1:0] next_stamp();
        if ($urandom_range(0, 99) < 4)
            stamp_now = {$urandom, $urandom};
        else
            stamp_now = stamp_now + TS_W'($urandom_range(0, 60));
        return stamp_now;
    endfunction

    task automatic queue_word(logic [1:0] kind, logic [IDX_W-1:0] idx, logic [TS_W-1:0] ts);
        t_in_word w;
        w.req_type     = kind;
        w.anchor_index = idx;
        w.timestamp    = ts;
        pending_events.push_back(w);
    endtask

    // driver: next word goes out at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_word  <= pending_events.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && !o_in_stall;
            quiet_cycles = quiet_cycles + 1;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(profile_event(i_in_word));
                words_in <= words_in + 1;
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result word: st=%0d ex=%h in=%h hit=%h",
                                 o_out_word.status, o_out_word.exclusive_time,
                                 o_out_word.inclusive_time, o_out_word.hit_total);
                end else begin
                    exp_w = expected_results.pop_front();
                    if (o_out_word.status !== exp_w.status ||
                        o_out_word.exclusive_time !== exp_w.exclusive_time ||
                        o_out_word.inclusive_time !== exp_w.inclusive_time ||
                        o_out_word.hit_total !== exp_w.hit_total) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch: exp st=%0d ex=%h in=%h hit=%h / got st=%0d ex=%h in=%h hit=%h",
                                     exp_w.status, exp_w.exclusive_time,
                                     exp_w.inclusive_time, exp_w.hit_total,
                                     o_out_word.status, o_out_word.exclusive_time,
                                     o_out_word.inclusive_time, o_out_word.hit_total);
                    end
                end
            end
        end
    end

    // watchdog: too long without any word moving
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        logic [IDX_W-1:0] pool [4];
        int unsigned      open_cnt;
        int unsigned      steps;
        int unsigned      dive;
        int unsigned      pick;
        int unsigned      random_base;

        for (int k = 0; k < ANCHORS; k++) begin
            excl_tbl[k] = '0;
            incl_tbl[k] = '0;
            hits_tbl[k] = '0;
        end
        open_depth = 0;
        parent_now = '0;
        stamp_now  = {$urandom, $urandom};

        // directed: empty end, extreme reads, no-op, wrapping elapsed, recursion
        queue_word(REQ_END,   '1, '1);
        queue_word(REQ_READ,  '0, '0);
        queue_word(REQ_READ,  '1, '1);
        queue_word(REQ_NOP,   '1, '1);
        queue_word(REQ_BEGIN, '1, '0);
        queue_word(REQ_BEGIN, IDX_W'(1), 64'd10);
        queue_word(REQ_END,   '0, 64'd30);
        queue_word(REQ_END,   IDX_W'(1), '1);
        queue_word(REQ_READ,  '1, 64'd0);
        queue_word(REQ_READ,  IDX_W'(1), 64'd0);
        queue_word(REQ_READ,  '0, 64'd0);
        // root used as an anchor, end earlier than begin
        queue_word(REQ_BEGIN, '0, 64'd5);
        queue_word(REQ_END,   '0, 64'd3);
        queue_word(REQ_READ,  '0, 64'd0);
        // recursive anchor: inclusive time must not double-count
        queue_word(REQ_BEGIN, IDX_W'(7), 64'd100);
        queue_word(REQ_BEGIN, IDX_W'(7), 64'd110);
        queue_word(REQ_END,   '0, 64'd130);
        queue_word(REQ_END,   '0, 64'd150);
        queue_word(REQ_READ,  IDX_W'(7), '1);
        queue_word(REQ_END,   '0, 64'h8000_0000_0000_0000);
        queue_word(REQ_NOP,   '0, '0);

        // random: mostly balanced scope trees, some stack dives and noise
        random_base = pending_events.size();
        while (pending_events.size() < random_base + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                for (int k = 0; k < 4; k++)
                    pool[k] = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 15))
                                                   : IDX_W'($urandom_range(0, ANCHORS - 1));
                open_cnt = 0;
                steps = $urandom_range(4, 20);
                for (int s = 0; s < steps; s++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 20) begin
                        queue_word(REQ_READ, pool[$urandom_range(0, 3)], next_stamp());
                    end else if (open_cnt == 0 || (open_cnt < 8 && pick < 60)) begin
                        queue_word(REQ_BEGIN, pool[$urandom_range(0, 3)], next_stamp());
                        open_cnt++;
                    end else begin
                        queue_word(REQ_END, IDX_W'($urandom_range(0, ANCHORS - 1)), next_stamp());
                        open_cnt--;
                    end
                end
                while (open_cnt > 0) begin
                    queue_word(REQ_END, IDX_W'($urandom_range(0, ANCHORS - 1)), next_stamp());
                    open_cnt--;
                end
                for (int k = 0; k < 4; k++)
                    queue_word(REQ_READ, pool[k], next_stamp());
            end else if (pick < 78) begin
                // run the stack near or past full, then pop one more than was pushed
                dive = $urandom_range(DEPTH - 4, DEPTH + 6);
                for (int s = 0; s < dive; s++)
                    queue_word(REQ_BEGIN, IDX_W'($urandom_range(0, 31)), next_stamp());
                for (int s = 0; s < dive + 1; s++)
                    queue_word(REQ_END, IDX_W'($urandom_range(0, ANCHORS - 1)), next_stamp());
                for (int s = 0; s < 4; s++)
                    queue_word(REQ_READ, IDX_W'($urandom_range(0, 31)), next_stamp());
            end else begin
                steps = $urandom_range(1, 8);
                for (int s = 0; s < steps; s++)
                    queue_word(2'($urandom_range(0, 3)), IDX_W'($urandom_range(0, ANCHORS - 1)),
                               {$urandom, $urandom});
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // drain: all words sent and every result back
        while (pending_events.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hw/rtl/hsp_pkg.sv
hw/rtl/hsp_datapath.sv
hw/rtl/hsp_ctrl.sv
hw/rtl/hierarchical_scope_profiler.sv
sim/hierarchical_scope_profiler_test.sv
